// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Implication form: antecedent |-> consequent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/owtps_pkg.sv =====
// ----------------------------------------------------------------------------
// owtps_pkg
// Types, constants and helpers for the one-wire temperature poll sequencer.
// ----------------------------------------------------------------------------
package owtps_pkg;

    localparam int SCRATCH_BYTES = 9;
    localparam int CNT_W         = $clog2(SCRATCH_BYTES + 1);
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [15:0] WAIT_TICKS_RST = 16'd800;
    localparam logic [7:0]  SKIP_ROM_RST   = 8'd204;
    localparam logic [7:0]  CONVERT_RST    = 8'd68;
    localparam logic [7:0]  READ_RST       = 8'd190;
    localparam logic [7:0]  CRC_POLY       = 8'h8C;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAIT_TICKS = 2'd0,
        CFG_SKIP_ROM   = 2'd1,
        CFG_CONVERT    = 2'd2,
        CFG_READ       = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_IDLE_STEP = 2'd0,
        OP_TICK      = 2'd1,
        OP_RX_BYTE   = 2'd2,
        OP_UNUSED    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_SEND  = 2'd2,
        CMD_RECV  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PRES1 = 3'd1,
        PH_WAIT1 = 3'd2,
        PH_WAIT2 = 3'd3,
        PH_PRES2 = 3'd4,
        PH_READ  = 3'd5,
        PH_CHECK = 3'd6
    } t_phase;

    typedef struct packed {
        logic [15:0] wait_ticks;
        logic [7:0]  skip_rom_code;
        logic [7:0]  convert_code;
        logic [7:0]  read_code;
    } t_cfg;

    typedef struct packed {
        logic [1:0] opcode;
        logic       presence_seen;
        logic       bus_error;
        logic [7:0] rx_data;
    } t_item;

    typedef struct packed {
        t_cmd               bus_command;
        logic [7:0]         tx_first;
        logic [7:0]         tx_second;
        logic               temp_valid;
        logic signed [15:0] temp_tenths;
    } t_result;

    // Dallas CRC-8, reflected, one byte.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc_in;
        d = data_in;
        for (int i = 0; i < 8; i++) begin
            mix = c[0] ^ d[0];
            c   = c >> 1;
            if (mix) begin
                c = c ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

    // raw * 10 / 16, truncated toward zero.
    function automatic logic signed [15:0] raw_to_tenths(input logic [15:0] raw);
        logic signed [19:0] ext;
        logic signed [19:0] prod;
        logic signed [19:0] adj;
        ext  = 20'(signed'(raw));
        prod = (ext <<< 3) + (ext <<< 1);
        adj  = prod + ((prod < 0) ? 20'sd15 : 20'sd0);
        return adj[19:4];
    endfunction

endpackage

// ===== hw/rtl/owtps_cfg.sv =====
// ----------------------------------------------------------------------------
// owtps_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module owtps_cfg
    import owtps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wait_ticks    <= WAIT_TICKS_RST;
            r_cfg.skip_rom_code <= SKIP_ROM_RST;
            r_cfg.convert_code  <= CONVERT_RST;
            r_cfg.read_code     <= READ_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WAIT_TICKS: r_cfg.wait_ticks    <= i_cfg_data;
                CFG_SKIP_ROM:   r_cfg.skip_rom_code <= i_cfg_data[7:0];
                CFG_CONVERT:    r_cfg.convert_code  <= i_cfg_data[7:0];
                CFG_READ:       r_cfg.read_code     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/owtps_seq.sv =====
// ----------------------------------------------------------------------------
// owtps_seq
// Poll sequencer state, conversion timer, scratchpad CRC and result logic.
// ----------------------------------------------------------------------------
module owtps_seq
    import owtps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_rx_cnt, n_rx_cnt;
    logic [7:0]         r_crc, n_crc;
    logic               r_crc_ok, n_crc_ok;
    logic [15:0]        r_raw, n_raw;
    logic [15:0]        r_wait_cnt, n_wait_cnt;
    logic               r_wait_run, n_wait_run;
    logic               r_wait_exp, n_wait_exp;
    logic signed [15:0] r_last_tenths, n_last_tenths;

    logic   w_step;
    logic   w_err;
    t_phase w_phase;
    logic   w_read_done;
    logic   w_rx_take;

    assign w_step      = (t_opcode'(i_item.opcode) == OP_IDLE_STEP);
    assign w_err       = w_step && i_item.bus_error;
    // bus error drops back to idle and the same step runs from there
    assign w_phase     = w_err ? PH_IDLE : r_phase;
    assign w_read_done = (r_rx_cnt >= CNT_W'(SCRATCH_BYTES)) && r_crc_ok;
    assign w_rx_take   = (t_opcode'(i_item.opcode) == OP_RX_BYTE) && (r_phase == PH_CHECK)
                         && (r_rx_cnt < CNT_W'(SCRATCH_BYTES));

    // next state
    always_comb begin
        logic [15:0] dec;
        n_phase       = r_phase;
        n_rx_cnt      = r_rx_cnt;
        n_crc         = r_crc;
        n_crc_ok      = r_crc_ok;
        n_raw         = r_raw;
        n_wait_cnt    = r_wait_cnt;
        n_wait_run    = r_wait_run;
        n_wait_exp    = r_wait_exp;
        n_last_tenths = r_last_tenths;
        dec           = (r_wait_cnt != 16'd0) ? (r_wait_cnt - 16'd1) : r_wait_cnt;

        case (t_opcode'(i_item.opcode))
            OP_TICK: begin
                if (r_wait_run) begin
                    n_wait_cnt = dec;
                    if (dec == 16'd0) begin
                        n_wait_run = 1'b0;
                        n_wait_exp = 1'b1;
                    end
                end
            end
            OP_RX_BYTE: begin
                if (w_rx_take) begin
                    if (r_rx_cnt < CNT_W'(SCRATCH_BYTES - 1)) begin
                        n_crc = crc8_byte(r_crc, i_item.rx_data);
                        if (r_rx_cnt == '0) begin
                            n_raw[7:0] = i_item.rx_data;
                        end else if (r_rx_cnt == CNT_W'(1)) begin
                            n_raw[15:8] = i_item.rx_data;
                        end
                    end else begin
                        n_crc_ok = (r_crc == i_item.rx_data);
                    end
                    n_rx_cnt = r_rx_cnt + CNT_W'(1);
                end
            end
            OP_IDLE_STEP: begin
                if (w_err) begin
                    n_wait_run = 1'b0;
                    n_wait_exp = 1'b0;
                    n_wait_cnt = 16'd0;
                end
                case (w_phase)
                    PH_IDLE:  n_phase = PH_PRES1;
                    PH_PRES1: n_phase = i_item.presence_seen ? PH_WAIT1 : PH_IDLE;
                    PH_WAIT1: begin
                        // start once; a running timer is left alone
                        if (!r_wait_run && !r_wait_exp) begin
                            n_wait_cnt = i_cfg.wait_ticks;
                            if (i_cfg.wait_ticks == 16'd0) begin
                                n_phase = PH_WAIT2;
                            end else begin
                                n_wait_run = 1'b1;
                            end
                        end else if (r_wait_exp) begin
                            n_wait_exp = 1'b0;
                            n_phase    = PH_WAIT2;
                        end
                    end
                    PH_WAIT2: n_phase = PH_PRES2;
                    PH_PRES2: n_phase = i_item.presence_seen ? PH_READ : PH_IDLE;
                    PH_READ: begin
                        n_rx_cnt = '0;
                        n_crc    = 8'd0;
                        n_crc_ok = 1'b0;
                        n_raw    = 16'd0;
                        n_phase  = PH_CHECK;
                    end
                    PH_CHECK: begin
                        if (w_read_done) begin
                            n_last_tenths = raw_to_tenths(r_raw);
                            n_phase       = PH_IDLE;
                        end else begin
                            n_phase = PH_PRES2;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            default: ;
        endcase
    end

    // result fields
    always_comb begin
        o_result.bus_command = CMD_NONE;
        o_result.tx_first    = 8'd0;
        o_result.tx_second   = 8'd0;
        o_result.temp_valid  = 1'b0;
        o_result.temp_tenths = n_last_tenths;
        if (w_step) begin
            case (w_phase)
                PH_IDLE, PH_WAIT2: o_result.bus_command = CMD_RESET;
                PH_PRES1: begin
                    if (i_item.presence_seen) begin
                        o_result.bus_command = CMD_SEND;
                        o_result.tx_first    = i_cfg.skip_rom_code;
                        o_result.tx_second   = i_cfg.convert_code;
                    end
                end
                PH_PRES2: begin
                    if (i_item.presence_seen) begin
                        o_result.bus_command = CMD_SEND;
                        o_result.tx_first    = i_cfg.skip_rom_code;
                        o_result.tx_second   = i_cfg.read_code;
                    end
                end
                PH_READ:  o_result.bus_command = CMD_RECV;
                PH_CHECK: begin
                    if (w_read_done) begin
                        o_result.temp_valid = 1'b1;
                    end else begin
                        o_result.bus_command = CMD_RESET;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_rx_cnt      <= '0;
            r_crc         <= 8'd0;
            r_crc_ok      <= 1'b0;
            r_raw         <= 16'd0;
            r_wait_cnt    <= 16'd0;
            r_wait_run    <= 1'b0;
            r_wait_exp    <= 1'b0;
            r_last_tenths <= 16'sd0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_rx_cnt      <= n_rx_cnt;
            r_crc         <= n_crc;
            r_crc_ok      <= n_crc_ok;
            r_raw         <= n_raw;
            r_wait_cnt    <= n_wait_cnt;
            r_wait_run    <= n_wait_run;
            r_wait_exp    <= n_wait_exp;
            r_last_tenths <= n_last_tenths;
        end
    end

endmodule

// ===== hw/rtl/onewire_temperature_poll_sequencer_core.sv =====
// Path: a beat accepted into the input register moves on into the result register
// when that register is free or being taken, and is then presented on the output.
// Throughput: one event per cycle while the output is not stalled; the input register
// advances whenever the result register is empty or being taken, so state updates once per event.
// Reset: synchronous, active low; clears both handshake stages, the sequencer
// state and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// onewire_temperature_poll_sequencer_core
// Top level: input register, sequencer, result register and config port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module onewire_temperature_poll_sequencer_core
    import owtps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_opcode,
    input  logic                  i_presence_seen,
    input  logic                  i_bus_error,
    input  logic [7:0]            i_rx_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_bus_command,
    output logic [7:0]            o_tx_first,
    output logic [7:0]            o_tx_second,
    output logic                  o_temp_valid,
    output logic signed [15:0]    o_temp_tenths
);

    t_cfg    w_cfg;
    t_result w_result;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    logic    w_fire;
    logic    w_accept;

    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    owtps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    owtps_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item.opcode        <= i_opcode;
            r_in_item.presence_seen <= i_presence_seen;
            r_in_item.bus_error     <= i_bus_error;
            r_in_item.rx_data       <= i_rx_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_bus_command = r_out.bus_command;
    assign o_tx_first    = r_out.tx_first;
    assign o_tx_second   = r_out.tx_second;
    assign o_temp_valid  = r_out.temp_valid;
    assign o_temp_tenths = r_out.temp_tenths;

    // a good read never issues a bus command in the same beat
    `ASSERT_IMPL(a_valid_no_cmd, i_clk, i_rst_n, o_out_valid && o_temp_valid,
        o_bus_command == CMD_NONE, "temperature beat carries a bus command")
    // send bytes only travel with a send command
    `ASSERT_IMPL(a_tx_zero, i_clk, i_rst_n, o_out_valid && (o_bus_command != CMD_SEND),
        (o_tx_first == 8'd0) && (o_tx_second == 8'd0), "tx bytes without send")
    `ASSERT_IMPL(a_tx_skip, i_clk, i_rst_n, o_out_valid && (o_bus_command == CMD_SEND),
        o_tx_first == w_cfg.skip_rom_code, "send beat lacks skip-ROM byte")
    // a processed beat always lands in the result register
    `ASSERT_CLK(a_fire_out, i_clk, i_rst_n, w_fire |=> o_out_valid,
        "processed event lost")

endmodule
